// File: rtl/sjfq_pkg.sv
// types, codes and constants shared by the shortest-job-first queue
`timescale 1ns / 1ps

package sjfq_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int ID_W            = 16;
   localparam int SIZE_W          = 16;
   localparam int OCC_W           = 6;

   typedef enum logic {
      CMD_INSERT  = 1'b0,
      CMD_DEQUEUE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_DROPPED  = 2'd1,
      ST_DEQUEUED = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_INS_SCAN,
      FSM_INS_PLACE,
      FSM_DEQ_HEAD,
      FSM_DEQ_SHIFT
   } fsm_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [ID_W-1:0]   job_id;
      logic [SIZE_W-1:0] job_size;
   } req_item_type;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   out_id;
      logic [SIZE_W-1:0] out_size;
      logic [OCC_W-1:0]  occupancy;
   } rsp_item_type;

   typedef struct packed {
      logic [ID_W-1:0]   job_id;
      logic [SIZE_W-1:0] job_size;
   } entry_type;

endpackage

// File: rtl/shortest_job_first_queue.sv
// shortest-job-first queue: sorted job store in one memory with a sequencer
`timescale 1ns / 1ps

//  channel  | direction | handshake                | payload
//  req_     | in        | req_valid / req_stall    | req_item  (cmd, job_id, job_size)
//  rsp_     | out       | rsp_valid / rsp_stall    | rsp_item  (status, out_id, out_size,
//           |           |                          |            occupancy)
//
//  insert into an empty queue, insert when full, dequeue when empty: answered from idle
//  other inserts: a one-entry-per-cycle backward scan from the tail through the single
//    memory read port, over the jobs larger than the new one, then the new job is placed
//  dequeue: head read, then a forward shift of the remaining jobs over the same port
//  synchronous reset clears the job count and control, memory is not cleared
//  an item is taken only in idle with the result register free or draining

module shortest_job_first_queue
   import sjfq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   // job store, sorted by size with entry 0 the smallest
   entry_type mem [QUEUE_DEPTH];
   entry_type mem_rd_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   entry_type        mem_wd;
   logic [IDX_W-1:0] mem_ra;

   fsm_type          state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   entry_type        key_ff, key_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   logic         req_fire;
   logic         rsp_free;
   logic         rsp_load;
   rsp_item_type rsp_next;

   // result register frees at this edge if it is empty or being taken
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == FSM_IDLE) && rsp_free);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      key_ff      <= key_in;
      rsp_item_ff <= rsp_item_in;
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      key_in   = key_ff;
      count_in = count_ff;
      mem_we   = 1'b0;
      mem_wa   = idx_ff;
      mem_wd   = key_ff;
      mem_ra   = idx_ff;
      rsp_load = 1'b0;
      rsp_next = '0;

      unique case (state_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               key_in = '{job_id: req_item.job_id, job_size: req_item.job_size};
               if (req_item.cmd == CMD_INSERT) begin
                  if (count_ff == FULL_CNT) begin
                     // full: job dropped, nothing changes
                     rsp_load        = 1'b1;
                     rsp_next.status = ST_DROPPED;
                  end else if (count_ff == '0) begin
                     // empty: job goes straight to the head
                     mem_we          = 1'b1;
                     mem_wa          = '0;
                     mem_wd          = '{job_id: req_item.job_id,
                                         job_size: req_item.job_size};
                     count_in        = CNT_W'(1);
                     rsp_load        = 1'b1;
                     rsp_next.status = ST_INSERTED;
                  end else begin
                     // scan from the tail towards the head
                     mem_ra   = IDX_W'(count_ff - 1'b1);
                     idx_in   = IDX_W'(count_ff - 1'b1);
                     state_in = FSM_INS_SCAN;
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_load        = 1'b1;
                     rsp_next.status = ST_EMPTY;
                  end else begin
                     mem_ra   = '0;
                     state_in = FSM_DEQ_HEAD;
                  end
               end
            end
         end

         FSM_INS_SCAN: begin
            // read data holds entry idx; larger sizes move up one place
            mem_we = 1'b1;
            mem_wa = IDX_W'(idx_ff + 1'b1);
            if (mem_rd_ff.job_size > key_ff.job_size) begin
               mem_wd = mem_rd_ff;
               if (idx_ff == '0) begin
                  state_in = FSM_INS_PLACE;
               end else begin
                  mem_ra = IDX_W'(idx_ff - 1'b1);
                  idx_in = IDX_W'(idx_ff - 1'b1);
               end
            end else begin
               // equal or smaller size stays ahead: new job lands behind it
               mem_wd          = key_ff;
               count_in        = CNT_W'(count_ff + 1'b1);
               rsp_load        = 1'b1;
               rsp_next.status = ST_INSERTED;
               state_in        = FSM_IDLE;
            end
         end

         FSM_INS_PLACE: begin
            // every held job was larger: new job becomes the head
            mem_we          = 1'b1;
            mem_wa          = '0;
            mem_wd          = key_ff;
            count_in        = CNT_W'(count_ff + 1'b1);
            rsp_load        = 1'b1;
            rsp_next.status = ST_INSERTED;
            state_in        = FSM_IDLE;
         end

         FSM_DEQ_HEAD: begin
            // head arrives; keep it in the key register during the shift
            key_in = mem_rd_ff;
            if (count_ff == CNT_W'(1)) begin
               count_in          = '0;
               rsp_load          = 1'b1;
               rsp_next.status   = ST_DEQUEUED;
               rsp_next.out_id   = mem_rd_ff.job_id;
               rsp_next.out_size = mem_rd_ff.job_size;
               state_in          = FSM_IDLE;
            end else begin
               mem_ra   = IDX_W'(1);
               idx_in   = IDX_W'(1);
               state_in = FSM_DEQ_SHIFT;
            end
         end

         FSM_DEQ_SHIFT: begin
            // entry idx moves down one place
            mem_we = 1'b1;
            mem_wa = IDX_W'(idx_ff - 1'b1);
            mem_wd = mem_rd_ff;
            if (idx_ff == IDX_W'(count_ff - 1'b1)) begin
               count_in          = CNT_W'(count_ff - 1'b1);
               rsp_load          = 1'b1;
               rsp_next.status   = ST_DEQUEUED;
               rsp_next.out_id   = key_ff.job_id;
               rsp_next.out_size = key_ff.job_size;
               state_in          = FSM_IDLE;
            end else begin
               mem_ra = IDX_W'(idx_ff + 1'b1);
               idx_in = IDX_W'(idx_ff + 1'b1);
            end
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase

      rsp_next.occupancy = OCC_W'(count_in);
   end

   // result register: load on finish, otherwise hold while stalled
   always_comb begin
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_item_in  = rsp_next;
         rsp_valid_in = 1'b1;
      end
   end

   // job count never exceeds the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("job count above depth");

   // the count only moves when a result is produced
   a_count_with_result: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> (rsp_valid_ff && !$past(reset)))
      else $error("count changed without a result");

   // a finish never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> rsp_free)
      else $error("result register overwritten");

   // dequeue from an empty queue answers on the next cycle
   a_empty_reply: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_item.cmd == CMD_DEQUEUE) && (count_ff == '0))
      |=> (rsp_valid_ff && (rsp_item_ff.status == ST_EMPTY)))
      else $error("empty dequeue not answered");

   // only idle takes new items
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != FSM_IDLE) |-> req_stall)
      else $error("item taken while busy");

endmodule
